// File: rtl/core/input_event_word_encoder_unit_macros.svh
// Assertion helpers used by the encoder back end (iewe_back).
`ifndef INPUT_EVENT_WORD_ENCODER_UNIT_MACROS_SVH
`define INPUT_EVENT_WORD_ENCODER_UNIT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define IEWE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a condition implies another in the same cycle.
`define IEWE_ASSERT_IMPL(lbl, ante, cons, msg) \
  `IEWE_ASSERT(lbl, (ante) |-> (cons), msg)

// Check that a condition implies another in the next cycle.
`define IEWE_ASSERT_NEXT(lbl, ante, cons, msg) \
  `IEWE_ASSERT(lbl, (ante) |=> (cons), msg)

`endif

// File: rtl/core/iewe_pkg.sv
package iewe_pkg;

  typedef enum logic [1:0] {
    OP_KEY    = 2'd0,
    OP_MOVE   = 2'd1,
    OP_BUTTON = 2'd2
  } opcode_e;

  typedef enum logic [3:0] {
    TY_DELTA = 4'd0,
    TY_XLOC  = 4'd1,
    TY_YLOC  = 4'd2,
    TY_ON    = 4'd3,
    TY_OFF   = 4'd4,
    TY_ABS   = 4'd5
  } ev_type_e;

  typedef enum logic [1:0] {
    CFG_FRAME_INTERVAL = 2'd0,
    CFG_MAX_PARAM      = 2'd1,
    CFG_SCREEN_WIDTH   = 2'd2,
    CFG_SCREEN_HEIGHT  = 2'd3
  } cfg_idx_e;

  typedef enum logic [1:0] {
    KC_NONE,
    KC_PLAIN,
    KC_SHIFTED
  } kcls_e;

  localparam logic [3:0]  SK_SHIFT       = 4'd7;
  localparam logic [3:0]  SK_LAST        = 4'd11;
  localparam logic [7:0]  SHIFT_KEY_CODE = 8'd136;
  localparam logic [7:0]  BTN_RED        = 8'd130;
  localparam logic [7:0]  BTN_YELLOW     = 8'd129;
  localparam logic [7:0]  BTN_BLUE       = 8'd128;
  localparam logic [11:0] POS_MAX        = 12'hFFF;

  localparam int unsigned CMD_DEPTH = 4;
  localparam int unsigned CMD_AW    = 2;
  localparam int unsigned CMD_CW    = 3;

  typedef struct packed {
    logic [1:0]         opcode;
    logic [3:0]         special_key;
    logic [7:0]         character;
    logic               is_down;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic [1:0]         button;
    logic [1:0]         modifiers;
    logic [31:0]        time_ms;
  } iewe_in_t;

  typedef struct packed {
    logic [15:0] event_word;
    logic        last;
  } iewe_out_t;

  typedef struct packed {
    logic [9:0]  frame_interval_ms;
    logic [11:0] max_param;
    logic [12:0] screen_width;
    logic [12:0] screen_height;
  } cfg_t;

  // One accepted item that posts one or two events.
  typedef struct packed {
    logic        abs_time;
    logic        two;
    logic [15:0] time_hi;
    logic [15:0] time_lo;
    logic [15:0] ev0;
    logic [15:0] ev1;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

  typedef struct packed {
    kcls_e      cls;
    logic [7:0] base;
  } kmap_t;

  function automatic logic [15:0] ev_word(ev_type_e ty, logic [11:0] p);
    return {ty, p};
  endfunction

  function automatic logic [7:0] special_code(logic [3:0] sk);
    logic [7:0] c;
    unique case (sk)
      4'd1:    c = 8'd8;
      4'd2:    c = 8'd9;
      4'd3:    c = 8'd13;
      4'd4:    c = 8'd27;
      4'd5:    c = 8'd32;
      4'd6:    c = 8'd127;
      4'd7:    c = SHIFT_KEY_CODE;
      4'd8:    c = 8'd138;
      4'd9:    c = 8'd139;
      4'd10:   c = 8'd95;
      4'd11:   c = 8'd94;
      default: c = 8'd0;
    endcase
    return c;
  endfunction

  function automatic kmap_t key_map(logic [7:0] ch);
    kmap_t r;
    r.cls  = KC_SHIFTED;
    r.base = ch;
    case (ch) inside
      [8'h61:8'h7A], [8'h30:8'h39],
      8'h2D, 8'h3D, 8'h5C, 8'h5B, 8'h5D, 8'h3B, 8'h27, 8'h2C, 8'h2E, 8'h2F:
        r.cls = KC_PLAIN;
      [8'h41:8'h5A]: r.base = ch + 8'd32;
      8'h2B: r.base = 8'h3D;
      8'h5F: r.base = 8'h2D;
      8'h7C: r.base = 8'h5C;
      8'h7B: r.base = 8'h5B;
      8'h7D: r.base = 8'h5D;
      8'h3A: r.base = 8'h3B;
      8'h22: r.base = 8'h27;
      8'h3C: r.base = 8'h2C;
      8'h3E: r.base = 8'h2E;
      8'h3F: r.base = 8'h2F;
      8'h21: r.base = 8'h31;
      8'h40: r.base = 8'h32;
      8'h23: r.base = 8'h33;
      8'h24: r.base = 8'h34;
      8'h25: r.base = 8'h35;
      8'h7E: r.base = 8'h36;
      8'h26: r.base = 8'h37;
      8'h2A: r.base = 8'h38;
      8'h28: r.base = 8'h39;
      8'h29: r.base = 8'h30;
      default: r.cls = KC_NONE;
    endcase
    return r;
  endfunction

  // Clamp a raw coordinate to [0, min(size - 1, 4095)].
  function automatic logic [11:0] clamp_pos(logic signed [15:0] v, logic [12:0] size);
    logic [12:0] lim13;
    logic [11:0] lim;
    lim13 = (size == 13'd0) ? 13'd0 : size - 13'd1;
    lim   = (lim13 > {1'b0, POS_MAX}) ? POS_MAX : lim13[11:0];
    if (v[15]) begin
      return 12'd0;
    end else if (16'(unsigned'(v)) > {4'h0, lim}) begin
      return lim;
    end
    return v[11:0];
  endfunction

endpackage

// File: rtl/core/iewe_front.sv
module iewe_front import iewe_pkg::*; #(
  parameter int unsigned TimeWidth = 32
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  cfg_t     cfg_i,
  input  iewe_in_t in_i,
  input  logic     accept_i,
  output logic     push_o,
  output cmd_t     cmd_o
);

  logic [TimeWidth-1:0] last_q, last_d, now, diff;
  logic [31:0]          now32, diff32;
  logic                 shift_q, shift_d;
  logic [11:0]          px_q, px_d, py_q, py_d;
  logic [11:0]          cx, cy, sx, sy;
  logic                 fits, frame_ok;
  logic [1:0]           np;
  logic [15:0]          ev0, ev1;
  ev_type_e             ty;
  kmap_t                km;

  assign now      = in_i.time_ms[TimeWidth-1:0];
  assign diff     = now - last_q;
  assign now32    = 32'(now);
  assign diff32   = 32'(diff);
  assign fits     = diff32 <= 32'(cfg_i.max_param);
  assign frame_ok = diff32 >= 32'(cfg_i.frame_interval_ms);
  assign cx       = clamp_pos(in_i.pos_x, cfg_i.screen_width);
  assign cy       = clamp_pos(in_i.pos_y, cfg_i.screen_height);
  assign sx       = (cx > cfg_i.max_param) ? cfg_i.max_param : cx;
  assign sy       = (cy > cfg_i.max_param) ? cfg_i.max_param : cy;
  assign km       = key_map(in_i.character);
  assign ty       = in_i.is_down ? TY_ON : TY_OFF;

  always_comb begin
    np      = 2'd0;
    ev0     = '0;
    ev1     = '0;
    shift_d = shift_q;
    px_d    = px_q;
    py_d    = py_q;
    unique case (in_i.opcode)
      OP_KEY: begin
        if (in_i.special_key != 4'd0 && in_i.special_key <= SK_LAST) begin
          np  = 2'd1;
          ev0 = ev_word(ty, {4'h0, special_code(in_i.special_key)});
          if (in_i.special_key == SK_SHIFT) begin
            shift_d = in_i.is_down;
          end
        end else begin
          case (km.cls)
            KC_PLAIN: begin
              // Unshifted key: lift a held shift around it.
              np  = 2'd1;
              ev0 = ev_word(ty, {4'h0, km.base});
              if (shift_q && in_i.is_down) begin
                np  = 2'd2;
                ev0 = ev_word(TY_OFF, {4'h0, SHIFT_KEY_CODE});
                ev1 = ev_word(ty, {4'h0, km.base});
              end else if (shift_q) begin
                np  = 2'd2;
                ev1 = ev_word(TY_ON, {4'h0, SHIFT_KEY_CODE});
              end
            end
            KC_SHIFTED: begin
              // Shifted key: press shift around it when not held.
              np  = 2'd1;
              ev0 = ev_word(ty, {4'h0, km.base});
              if (!shift_q && in_i.is_down) begin
                np  = 2'd2;
                ev0 = ev_word(TY_ON, {4'h0, SHIFT_KEY_CODE});
                ev1 = ev_word(ty, {4'h0, km.base});
              end else if (!shift_q) begin
                np  = 2'd2;
                ev1 = ev_word(TY_OFF, {4'h0, SHIFT_KEY_CODE});
              end
            end
            default: np = 2'd0;
          endcase
        end
      end
      OP_MOVE: begin
        px_d = cx;
        py_d = cy;
        if (frame_ok) begin
          if (cx != px_q && cy != py_q) begin
            np  = 2'd2;
            ev0 = ev_word(TY_XLOC, sx);
            ev1 = ev_word(TY_YLOC, sy);
          end else if (cx != px_q) begin
            np  = 2'd1;
            ev0 = ev_word(TY_XLOC, sx);
          end else if (cy != py_q) begin
            np  = 2'd1;
            ev0 = ev_word(TY_YLOC, sy);
          end
        end
      end
      OP_BUTTON: begin
        np = 2'd1;
        case (in_i.button)
          2'd1: begin
            case (in_i.modifiers)
              2'd0:    ev0 = ev_word(ty, {4'h0, BTN_RED});
              2'd1:    ev0 = ev_word(ty, {4'h0, BTN_YELLOW});
              2'd3:    ev0 = ev_word(ty, {4'h0, BTN_BLUE});
              default: np = 2'd0;
            endcase
          end
          2'd2: ev0 = ev_word(ty, {4'h0, (in_i.modifiers == 2'd2) ? BTN_BLUE : BTN_YELLOW});
          2'd3: ev0 = ev_word(ty, {4'h0, BTN_BLUE});
          default: np = 2'd0;
        endcase
      end
      default: np = 2'd0;
    endcase
  end

  assign last_d = (np != 2'd0) ? now : last_q;
  assign push_o = accept_i && (np != 2'd0);

  // The second event of an item always follows with a zero delta.
  always_comb begin
    cmd_o.abs_time = !fits;
    cmd_o.two      = (np == 2'd2);
    cmd_o.time_hi  = now32[31:16];
    cmd_o.time_lo  = fits ? ev_word(TY_DELTA, diff[11:0]) : now32[15:0];
    cmd_o.ev0      = ev0;
    cmd_o.ev1      = ev1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q  <= '0;
      shift_q <= 1'b0;
      px_q    <= '0;
      py_q    <= '0;
    end else if (accept_i) begin
      last_q  <= last_d;
      shift_q <= shift_d;
      px_q    <= px_d;
      py_q    <= py_d;
    end
  end

endmodule

// File: rtl/core/iewe_cmd_fifo.sv
module iewe_cmd_fifo import iewe_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  cmd_t       cmd_i,
  input  logic       pop_i,
  output cmd_t       cmd_o,
  output fifo_stat_t stat_o
);

  cmd_t              mem_q [CMD_DEPTH];
  logic [CMD_AW-1:0] wr_q, rd_q;
  logic [CMD_CW-1:0] cnt_q, cnt_d;
  logic              do_push, do_pop;

  assign stat_o.full  = (cnt_q == CMD_CW'(CMD_DEPTH));
  assign stat_o.empty = (cnt_q == '0);
  assign do_push      = push_i && !stat_o.full;
  assign do_pop       = pop_i && !stat_o.empty;
  assign cmd_o        = mem_q[rd_q];

  always_comb begin
    cnt_d = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (do_push) begin
        wr_q <= wr_q + 1'b1;
      end
      if (do_pop) begin
        rd_q <= rd_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= cmd_i;
    end
  end

endmodule

// File: rtl/core/iewe_back.sv
`include "input_event_word_encoder_unit_macros.svh"

module iewe_back import iewe_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cmd_t       head_i,
  input  fifo_stat_t stat_i,
  output logic       cmd_pop_o,
  output iewe_out_t  out_o,
  output logic       empty_o,
  input  logic       pop_i
);

  // Word slots of one command; without absolute time it starts at SLOT_LO.
  localparam logic [2:0] SLOT_ABS   = 3'd0;
  localparam logic [2:0] SLOT_HI    = 3'd1;
  localparam logic [2:0] SLOT_LO    = 3'd2;
  localparam logic [2:0] SLOT_EV0   = 3'd3;
  localparam logic [2:0] SLOT_DELTA = 3'd4;
  localparam logic [2:0] SLOT_EV1   = 3'd5;

  logic [2:0]  step_q, step_d, slot;
  logic        head_valid, issue, is_last;
  logic        oval_q, oval_d;
  logic [15:0] word;
  iewe_out_t   out_q;

  assign head_valid = !stat_i.empty;
  assign slot       = step_q + (head_i.abs_time ? SLOT_ABS : SLOT_LO);
  assign is_last    = (slot == SLOT_EV1) || (slot == SLOT_EV0 && !head_i.two);
  assign issue      = head_valid && (!oval_q || pop_i);
  assign cmd_pop_o  = issue && is_last;

  always_comb begin
    unique case (slot)
      SLOT_ABS:   word = ev_word(TY_ABS, 12'h000);
      SLOT_HI:    word = head_i.time_hi;
      SLOT_LO:    word = head_i.time_lo;
      SLOT_EV0:   word = head_i.ev0;
      SLOT_DELTA: word = ev_word(TY_DELTA, 12'h000);
      SLOT_EV1:   word = head_i.ev1;
      default:    word = '0;
    endcase
  end

  // Advance through the slots, restart on the last word.
  assign step_d = !issue ? step_q : (is_last ? 3'd0 : step_q + 3'd1);
  assign oval_d = issue ? 1'b1 : (pop_i ? 1'b0 : oval_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
      oval_q <= 1'b0;
    end else begin
      step_q <= step_d;
      oval_q <= oval_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      out_q.event_word <= word;
      out_q.last       <= is_last;
    end
  end

  assign out_o   = out_q;
  assign empty_o = !oval_q;

  `IEWE_ASSERT_IMPL(a_slot_range, head_valid, slot <= SLOT_EV1, "slot beyond last word")
  `IEWE_ASSERT_IMPL(a_idle_step, !head_valid, step_q == 3'd0, "step moved without command")
  `IEWE_ASSERT_NEXT(a_last_restart, issue && is_last, step_q == 3'd0, "step not restarted")
  `IEWE_ASSERT_IMPL(a_pop_head, cmd_pop_o, head_valid, "command pop while queue empty")

endmodule

// File: rtl/core/input_event_word_encoder_unit.sv
// Input event word encoder. Key, pointer-move and button events go in as one word
// each and come out as 16-bit event words, every event preceded by a delta time
// word or by an absolute marker and two raw time halves. The front takes one item
// per cycle while its four-entry command queue has room and updates the shift,
// pointer and time state at once; the back drains the queue at one output word
// per cycle unless a word waits unpopped in the output register. An item makes
// 2, 4 or 6 words, and an item that makes no words is not queued. The output word
// register lets the front keep accepting while a result waits to be popped.
// Configuration writes are always ready and take effect on the next item.
module input_event_word_encoder_unit import iewe_pkg::*; #(
  parameter int unsigned TIME_WIDTH = 32
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push,
  output logic      full,
  input  iewe_in_t  in_data_i,
  output logic      empty,
  input  logic      pop,
  output iewe_out_t out_data_o,
  input  logic      cfg_valid_i,
  output logic      cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [12:0] cfg_data_i
);

  cfg_t       cfg_q;
  logic       accept, cmd_push, cmd_pop;
  cmd_t       cmd_in, cmd_head;
  fifo_stat_t fifo_stat;

  assign cfg_ready_o = 1'b1;
  assign full        = fifo_stat.full;
  assign accept      = push && !fifo_stat.full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.frame_interval_ms <= 10'd20;
      cfg_q.max_param         <= 12'd4095;
      cfg_q.screen_width      <= 13'd640;
      cfg_q.screen_height     <= 13'd480;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_FRAME_INTERVAL: cfg_q.frame_interval_ms <= cfg_data_i[9:0];
        CFG_MAX_PARAM:      cfg_q.max_param         <= cfg_data_i[11:0];
        CFG_SCREEN_WIDTH:   cfg_q.screen_width      <= cfg_data_i;
        CFG_SCREEN_HEIGHT:  cfg_q.screen_height     <= cfg_data_i;
        default:            cfg_q <= cfg_q;
      endcase
    end
  end

  iewe_front #(
    .TimeWidth (TIME_WIDTH)
  ) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_q),
    .in_i     (in_data_i),
    .accept_i (accept),
    .push_o   (cmd_push),
    .cmd_o    (cmd_in)
  );

  iewe_cmd_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (cmd_push),
    .cmd_i  (cmd_in),
    .pop_i  (cmd_pop),
    .cmd_o  (cmd_head),
    .stat_o (fifo_stat)
  );

  iewe_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .head_i    (cmd_head),
    .stat_i    (fifo_stat),
    .cmd_pop_o (cmd_pop),
    .out_o     (out_data_o),
    .empty_o   (empty),
    .pop_i     (pop)
  );

endmodule

// File: test/tb_input_event_word_encoder_unit.sv
module tb_input_event_word_encoder_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import iewe_pkg::*;

  localparam logic [1:0]  OP_UNUSED = 2'd3;
  localparam logic [3:0]  SK_NONE = 4'd0;
  localparam logic [3:0]  SK_FIRST = 4'd1;
  localparam logic [3:0]  SK_TOP = 4'd15;
  localparam logic [7:0]  KEY_CODES [12] = '{8'd0, 8'd8, 8'd9, 8'd13, 8'd27, 8'd32, 8'd127,
                                             8'd136, 8'd138, 8'd139, 8'd95, 8'd94};
  localparam logic [11:0] SHIFT_CODE = 12'd136;
  localparam logic [11:0] CODE_RED = 12'd130;
  localparam logic [11:0] CODE_YELLOW = 12'd129;
  localparam logic [11:0] CODE_BLUE = 12'd128;
  localparam logic [1:0]  BTN_NONE = 2'd0;
  localparam logic [1:0]  BTN_LEFT = 2'd1;
  localparam logic [1:0]  BTN_RIGHT = 2'd2;
  localparam logic [1:0]  BTN_MIDDLE = 2'd3;
  localparam logic [1:0]  MOD_NONE = 2'd0;
  localparam logic [1:0]  MOD_CTRL = 2'd1;
  localparam logic [1:0]  MOD_SHIFT = 2'd2;
  localparam logic [1:0]  MOD_BOTH = 2'd3;
  localparam logic [7:0]  CH_LOW = "!";
  localparam logic [7:0]  CH_HIGH = "~";
  localparam logic [12:0] POS_LIMIT = 13'd4095;
  localparam int unsigned QUIET_LIMIT = 2000;
  localparam int unsigned SETTLE_CYCLES = 16;
  localparam int unsigned PHASES = 5;
  localparam int unsigned PHASE_ITEMS = 77;

  // Predicts the event words of each accepted item and checks them in order.
  class event_word_tracker;
    logic [9:0]  frame_ms;
    logic [11:0] max_prm;
    logic [12:0] scr_w;
    logic [12:0] scr_h;
    logic [31:0] last_ms;
    logic [31:0] now_ms;
    bit          shift_on;
    logic [11:0] ptr_x;
    logic [11:0] ptr_y;
    logic [15:0] item_words[$];
    iewe_out_t   expected_words[$];
    int unsigned items;
    int unsigned words;
    int unsigned abs_marks;
    int unsigned errors;

    function new();
      frame_ms = 10'd20;
      max_prm = 12'd4095;
      scr_w = 13'd640;
      scr_h = 13'd480;
      last_ms = '0;
      shift_on = 1'b0;
      ptr_x = '0;
      ptr_y = '0;
      items = 0;
      words = 0;
      abs_marks = 0;
      errors = 0;
    endfunction

    function int pending();
      return expected_words.size();
    endfunction

    function void set_reg(cfg_idx_e idx, logic [12:0] v);
      case (idx)
        CFG_FRAME_INTERVAL: frame_ms = v[9:0];
        CFG_MAX_PARAM:      max_prm = v[11:0];
        CFG_SCREEN_WIDTH:   scr_w = v;
        CFG_SCREEN_HEIGHT:  scr_h = v;
        default: ;
      endcase
    endfunction

    function void put(logic [15:0] w);
      if (item_words.size() < 6) item_words.push_back(w);
    endfunction

    // Time word (delta or absolute marker plus halves), then the event itself.
    function void post_event(ev_type_e ty, logic [11:0] p);
      logic [31:0] gap;
      gap = now_ms - last_ms;
      last_ms = now_ms;
      if (gap <= {20'd0, max_prm}) begin
        put({TY_DELTA, gap[11:0]});
      end else begin
        put({TY_ABS, 12'd0});
        put(now_ms[31:16]);
        put(now_ms[15:0]);
        abs_marks++;
      end
      put({ty, p});
    endfunction

    function bit key_base(logic [7:0] ch, output logic [7:0] base, output bit plain);
      string from_s;
      string to_s;
      from_s = "+_|{}:\"<>?!@#$%~&*()";
      to_s = "=-\\[];',./1234567890";
      plain = 1'b1;
      base = ch;
      if (ch < CH_LOW || ch > CH_HIGH) return 1'b0;
      if ((ch >= "a" && ch <= "z") || (ch >= "0" && ch <= "9")) return 1'b1;
      case (ch)
        "-", "=", "\\", "[", "]", ";", "'", ",", ".", "/": return 1'b1;
        default: ;
      endcase
      plain = 1'b0;
      if (ch >= "A" && ch <= "Z") begin
        base = ch + 8'd32;
        return 1'b1;
      end
      for (int i = 0; i < from_s.len(); i++) begin
        if (from_s.getc(i) == ch) begin
          base = to_s.getc(i);
          return 1'b1;
        end
      end
      return 1'b0;
    endfunction

    function void key_event(logic [3:0] sk, logic [7:0] ch, bit down);
      ev_type_e    ty;
      logic [7:0]  base;
      bit          plain;
      ty = down ? TY_ON : TY_OFF;
      if (sk >= SK_FIRST && sk <= SK_LAST) begin
        if (sk == SK_SHIFT) shift_on = down;
        post_event(ty, {4'd0, KEY_CODES[sk]});
        return;
      end
      if (!key_base(ch, base, plain)) return;
      // Shift state must read as the key's layout demands, then be restored.
      if (plain) begin
        if (down && shift_on) post_event(TY_OFF, SHIFT_CODE);
        post_event(ty, {4'd0, base});
        if (!down && shift_on) post_event(TY_ON, SHIFT_CODE);
      end else begin
        if (down && !shift_on) post_event(TY_ON, SHIFT_CODE);
        post_event(ty, {4'd0, base});
        if (!down && !shift_on) post_event(TY_OFF, SHIFT_CODE);
      end
    endfunction

    function logic [11:0] clamp_axis(logic signed [15:0] raw, logic [12:0] size);
      logic [12:0] lim;
      lim = (size == 13'd0) ? 13'd0 : size - 13'd1;
      if (lim > POS_LIMIT) lim = POS_LIMIT;
      if (raw[15]) return 12'd0;
      if ($unsigned(raw) > {3'b000, lim}) return lim[11:0];
      return raw[11:0];
    endfunction

    function void move_event(logic signed [15:0] x, logic signed [15:0] y);
      logic [11:0] ox;
      logic [11:0] oy;
      logic [31:0] gap;
      ox = ptr_x;
      oy = ptr_y;
      ptr_x = clamp_axis(x, scr_w);
      ptr_y = clamp_axis(y, scr_h);
      gap = now_ms - last_ms;
      if (gap < {22'd0, frame_ms}) return;
      if (ox != ptr_x) post_event(TY_XLOC, (ptr_x > max_prm) ? max_prm : ptr_x);
      if (oy != ptr_y) post_event(TY_YLOC, (ptr_y > max_prm) ? max_prm : ptr_y);
    endfunction

    function void button_event(logic [1:0] btn, logic [1:0] mods, bit down);
      ev_type_e ty;
      ty = down ? TY_ON : TY_OFF;
      case (btn)
        BTN_LEFT: begin
          if (mods == MOD_NONE) post_event(ty, CODE_RED);
          else if (mods == MOD_CTRL) post_event(ty, CODE_YELLOW);
          else if (mods == MOD_BOTH) post_event(ty, CODE_BLUE);
        end
        BTN_RIGHT:  post_event(ty, (mods == MOD_SHIFT) ? CODE_BLUE : CODE_YELLOW);
        BTN_MIDDLE: post_event(ty, CODE_BLUE);
        default: ;
      endcase
    endfunction

    function void note_event(iewe_in_t ev);
      iewe_out_t w;
      item_words.delete();
      now_ms = ev.time_ms;
      items++;
      case (ev.opcode)
        OP_KEY:    key_event(ev.special_key, ev.character, ev.is_down);
        OP_MOVE:   move_event(ev.pos_x, ev.pos_y);
        OP_BUTTON: button_event(ev.button, ev.modifiers, ev.is_down);
        default: ;
      endcase
      foreach (item_words[i]) begin
        w.event_word = item_words[i];
        w.last = (i == item_words.size() - 1);
        expected_words.push_back(w);
      end
    endfunction

    function void check_word(iewe_out_t got);
      iewe_out_t want;
      if (expected_words.size() == 0) begin
        errors++;
        $display("%0t: word %h (last %b) with nothing expected", $time, got.event_word,
                 got.last);
        return;
      end
      want = expected_words.pop_front();
      words++;
      if (got.event_word !== want.event_word) begin
        errors++;
        $display("%0t: event_word expected %h actual %h", $time, want.event_word,
                 got.event_word);
      end
      if (got.last !== want.last) begin
        errors++;
        $display("%0t: last expected %b actual %b (word %h)", $time, want.last, got.last,
                 want.event_word);
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        push = 1'b0;
  logic        full;
  iewe_in_t    in_data_i = '0;
  logic        empty;
  logic        pop = 1'b0;
  iewe_out_t   out_data_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = '0;
  logic [12:0] cfg_data_i = '0;

  event_word_tracker tracker;
  logic [31:0] tick_ms = '0;
  int unsigned burst_left = 0;
  int unsigned rx_mode = 0;
  int unsigned stall_left = 0;
  int unsigned quiet_cycles = 0;
  int unsigned reg_writes = 0;

  input_event_word_encoder_unit dut (
    .clk_i,
    .rst_ni,
    .push,
    .full,
    .in_data_i,
    .empty,
    .pop,
    .out_data_o,
    .cfg_valid_i,
    .cfg_ready_o,
    .cfg_index_i,
    .cfg_data_i
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Receiver: pop freely, with short or long stalls depending on the mode.
  always @(posedge clk_i) begin
    if (stall_left != 0) begin
      pop <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      pop <= 1'b1;
      if (rx_mode != 0 && $urandom_range(0, 4) == 0)
        stall_left <= $urandom_range(1, (rx_mode == 2) ? 12 : 3);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (pop && !empty) tracker.check_word(out_data_o);
      if (push && !full) tracker.note_event(in_data_i);
      if (cfg_valid_i && cfg_ready_o) begin
        tracker.set_reg(cfg_idx_e'(cfg_index_i), cfg_data_i);
        reg_writes++;
      end
      if ((pop && !empty) || (push && !full) || (cfg_valid_i && cfg_ready_o)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
          $display("%0t: no handshake for %0d cycles, %0d words outstanding", $time,
                   quiet_cycles, tracker.pending());
          $display("input_event_word_encoder_unit test failed");
          $finish;
        end
      end
    end
  end

  function automatic iewe_in_t noise_event();
    logic [95:0] bits96;
    bits96 = {$urandom(), $urandom(), $urandom()};
    return bits96[$bits(iewe_in_t)-1:0];
  endfunction

  function automatic iewe_in_t key_evt(logic [3:0] sk, logic [7:0] ch, bit down, int dt);
    iewe_in_t ev;
    ev = noise_event();
    tick_ms += dt;
    ev.opcode = OP_KEY;
    ev.special_key = sk;
    ev.character = ch;
    ev.is_down = down;
    ev.time_ms = tick_ms;
    return ev;
  endfunction

  function automatic iewe_in_t move_evt(logic signed [15:0] x, logic signed [15:0] y, int dt);
    iewe_in_t ev;
    ev = noise_event();
    tick_ms += dt;
    ev.opcode = OP_MOVE;
    ev.pos_x = x;
    ev.pos_y = y;
    ev.time_ms = tick_ms;
    return ev;
  endfunction

  function automatic iewe_in_t button_evt(logic [1:0] btn, logic [1:0] mods, bit down, int dt);
    iewe_in_t ev;
    ev = noise_event();
    tick_ms += dt;
    ev.opcode = OP_BUTTON;
    ev.button = btn;
    ev.modifiers = mods;
    ev.is_down = down;
    ev.time_ms = tick_ms;
    return ev;
  endfunction

  // Mostly human-paced ticks; now and then a long pause or a jump anywhere.
  function automatic void step_clock();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 55) tick_ms += $urandom_range(0, 40);
    else if (pick < 80) tick_ms += $urandom_range(41, 1500);
    else if (pick < 92) tick_ms += $urandom_range(4000, 200000);
    else if (pick >= 96) tick_ms = $urandom();
  endfunction

  function automatic iewe_in_t random_event();
    iewe_in_t    ev;
    int unsigned pick;
    ev = noise_event();
    step_clock();
    ev.time_ms = tick_ms;
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      ev.opcode = OP_KEY;
      pick = $urandom_range(0, 99);
      if (pick < 15) begin
        ev.special_key = SK_SHIFT;
      end else if (pick < 28) begin
        ev.special_key = 4'($urandom_range(SK_FIRST, SK_LAST));
      end else if (pick < 33) begin
        ev.special_key = 4'($urandom_range(SK_LAST + 1, SK_TOP));
      end else begin
        ev.special_key = SK_NONE;
        if ($urandom_range(0, 4) != 0) ev.character = 8'($urandom_range(CH_LOW, CH_HIGH));
      end
    end else if (pick < 75) begin
      ev.opcode = OP_MOVE;
      if ($urandom_range(0, 3) != 0) begin
        ev.pos_x = 16'($urandom_range(0, 700));
        ev.pos_y = 16'($urandom_range(0, 700));
      end
    end else if (pick < 95) begin
      ev.opcode = OP_BUTTON;
    end else begin
      ev.opcode = OP_UNUSED;
    end
    return ev;
  endfunction

  // Hold push until the word is taken; open a new burst after a random gap.
  task automatic send_word(input iewe_in_t ev);
    if (burst_left == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 5) == 0) ? 40 : $urandom_range(1, 10);
    end
    push <= 1'b1;
    in_data_i <= ev;
    do @(posedge clk_i); while (full);
    burst_left--;
  endtask

  // Drop push and wait for every expected word, then let the back end go quiet.
  task automatic drain_words();
    push <= 1'b0;
    burst_left = 0;
    do @(negedge clk_i); while (tracker.pending() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [12:0] value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic apply_settings(input logic [12:0] frame, input logic [12:0] maxp,
                                input logic [12:0] width, input logic [12:0] height);
    write_reg(CFG_FRAME_INTERVAL, frame);
    write_reg(CFG_MAX_PARAM, maxp);
    write_reg(CFG_SCREEN_WIDTH, width);
    write_reg(CFG_SCREEN_HEIGHT, height);
  endtask

  initial begin
    iewe_in_t ev;
    tracker = new();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    rx_mode <= 1;
    @(posedge clk_i);

    // Directed pass under the reset settings.
    send_word(key_evt(SK_NONE, "a", 1'b1, 5));
    send_word(key_evt(SK_NONE, "A", 1'b1, 3));
    send_word(key_evt(SK_NONE, "A", 1'b0, 2));
    send_word(key_evt(SK_SHIFT, 8'd0, 1'b1, 4));
    send_word(key_evt(SK_NONE, "a", 1'b1, 1));
    send_word(key_evt(SK_NONE, "a", 1'b0, 1));
    send_word(key_evt(SK_NONE, "!", 1'b1, 1));
    send_word(key_evt(SK_SHIFT, 8'd0, 1'b0, 1));
    send_word(key_evt(SK_FIRST, 8'd0, 1'b1, 1));
    send_word(key_evt(SK_LAST, 8'd0, 1'b0, 1));
    send_word(key_evt(SK_TOP, "z", 1'b1, 1));
    send_word(key_evt(SK_NONE, 8'hFF, 1'b1, 1));
    send_word(move_evt(16'sh8000, 16'sh7FFF, 30));
    send_word(move_evt(16'sh7FFF, -16'sd1, 25));
    send_word(move_evt(16'sd100, 16'sd100, 3));
    send_word(button_evt(BTN_LEFT, MOD_NONE, 1'b1, 2));
    send_word(button_evt(BTN_LEFT, MOD_SHIFT, 1'b1, 2));
    send_word(button_evt(BTN_LEFT, MOD_BOTH, 1'b0, 2));
    send_word(button_evt(BTN_RIGHT, MOD_SHIFT, 1'b1, 2));
    send_word(button_evt(BTN_RIGHT, MOD_CTRL, 1'b0, 2));
    send_word(button_evt(BTN_MIDDLE, MOD_NONE, 1'b1, 2));
    send_word(button_evt(BTN_NONE, MOD_BOTH, 1'b1, 2));
    // Far jump forces an absolute time; the next tick wraps past zero.
    tick_ms = 32'hFFFF_FFF0;
    send_word(button_evt(BTN_MIDDLE, MOD_NONE, 1'b0, 0));
    send_word(button_evt(BTN_LEFT, MOD_CTRL, 1'b1, 32));
    ev = noise_event();
    ev.opcode = OP_UNUSED;
    ev.time_ms = tick_ms;
    send_word(ev);
    drain_words();

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: apply_settings(13'd0, 13'd4095, 13'd4096, 13'd4096);
        1: apply_settings(13'd1023, 13'd0, 13'd0, 13'd1);
        2: apply_settings(13'd5, 13'd100, 13'd8191, 13'd300);
        3: apply_settings(13'd20, 13'd1, 13'd1, 13'd8191);
        default: apply_settings(13'($urandom_range(0, 1023)), 13'($urandom_range(0, 4095)),
                                13'($urandom_range(0, 8191)), 13'($urandom_range(0, 8191)));
      endcase
      rx_mode <= p % 3;
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        send_word(random_event());
        if ($urandom_range(0, 39) == 0) drain_words();
      end
      drain_words();
    end

    $display("Covered %0d input events, %0d event words checked, %0d absolute time markers.",
             tracker.items, tracker.words, tracker.abs_marks);
    $display("%0d register writes from reset values through zero and full-scale settings.",
             reg_writes);
    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("input_event_word_encoder_unit test passed");
    end else begin
      $display("input_event_word_encoder_unit test failed");
    end
    $finish;
  end

endmodule
